>>> sv/tcrt_pkg.sv
`timescale 1ns / 1ps

package tcrt_pkg;

  // Contact table geometry and fixed point format
  localparam int NUM_CONTACTS  = 16;
  localparam int FRACTION_BITS = 8;
  localparam int CID_W         = (NUM_CONTACTS > 1) ? $clog2(NUM_CONTACTS) : 1;

  // Field widths
  localparam int ID_W       = 8;
  localparam int PHASE_W    = 2;
  localparam int RAW_W      = 15;
  localparam int SIZE_W     = 14;
  localparam int SENS_W     = 16;
  localparam int PIX_W      = 13;
  localparam int PRES_W     = 11;
  localparam int OUT_ID_W   = 6;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Virtual position: integer pixels plus fraction
  localparam int POS_W = PIX_W + FRACTION_BITS;

  // Arithmetic widths
  localparam int PROD_W     = RAW_W + SIZE_W;
  localparam int GAIN_SHIFT = 8;
  localparam int UP_SH      = (FRACTION_BITS > GAIN_SHIFT) ? FRACTION_BITS - GAIN_SHIFT : 0;
  localparam int DN_SH      = (FRACTION_BITS < GAIN_SHIFT) ? GAIN_SHIFT - FRACTION_BITS : 0;
  localparam int DIV_W      = PROD_W + SENS_W + UP_SH;
  localparam int NV_W       = DIV_W + 2;
  localparam int PRES_SHIFT = 10;

  // Divide by 2^SCALE_SH - 1 through folding of SCALE_SH-bit digits
  localparam int SCALE_SH  = 15;
  localparam int DIV_STEPS = (DIV_W + SCALE_SH - 1) / SCALE_SH + 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [SCALE_SH-1:0] FULL_SCALE = {SCALE_SH{1'b1}};

  // Divider lanes
  localparam int NUM_LANES = 3;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;
  localparam int LANE_P    = 2;

  // Screen size limits and edge margin
  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(8192);
  localparam logic [SIZE_W-1:0] EDGE     = SIZE_W'(2);

  // Register reset values
  localparam logic                  RST_ENABLE      = 1'b0;
  localparam logic [SIZE_W-1:0]     RST_SCREEN_W    = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0]     RST_SCREEN_H    = SIZE_W'(1080);
  localparam logic [SENS_W-1:0]     RST_SENSITIVITY = SENS_W'(256);

  // Report phases
  localparam logic [PHASE_W-1:0] PH_TOUCH = 2'd1;
  localparam logic [PHASE_W-1:0] PH_LIFT  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_SENS   = 2'd3
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [RAW_W-1:0] last_x;
    logic [RAW_W-1:0] last_y;
    logic [POS_W-1:0] virt_x;
    logic [POS_W-1:0] virt_y;
  } entry_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

>>> sv/tcrt_rpt_if.sv
`timescale 1ns / 1ps

interface tcrt_rpt_if import tcrt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ID_W-1:0]    contact_id;
  logic [PHASE_W-1:0]        touch_phase;
  logic [RAW_W-1:0]          raw_x;
  logic [RAW_W-1:0]          raw_y;
  logic [RAW_W-1:0]          raw_pressure;

  modport source (
    output valid, contact_id, touch_phase, raw_x, raw_y, raw_pressure,
    input  ready
  );

  modport sink (
    input  valid, contact_id, touch_phase, raw_x, raw_y, raw_pressure,
    output ready
  );
endinterface

>>> sv/tcrt_evt_if.sv
`timescale 1ns / 1ps

interface tcrt_evt_if import tcrt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_ID_W-1:0] out_contact;
  logic [KIND_W-1:0]   event_kind;
  logic [PIX_W-1:0]    pixel_x;
  logic [PIX_W-1:0]    pixel_y;
  logic [PRES_W-1:0]   pressure_level;

  modport source (
    output valid, out_contact, event_kind, pixel_x, pixel_y, pressure_level,
    input  ready
  );

  modport sink (
    input  valid, out_contact, event_kind, pixel_x, pixel_y, pressure_level,
    output ready
  );
endinterface

>>> sv/tcrt_cfg_if.sv
`timescale 1ns / 1ps

interface tcrt_cfg_if import tcrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

>>> sv/tcrt_div.sv
`timescale 1ns / 1ps

// Three-lane iterative divide by FULL_SCALE (2^15 - 1). Each step folds the
// upper digits of the remainder back onto the lower digits and adds them to
// the quotient; a final step corrects a remainder equal to FULL_SCALE.
module tcrt_div import tcrt_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  div_ctrl_t                           ctrl,
  input  logic [NUM_LANES-1:0][DIV_W-1:0]     num,
  output div_stat_t                           stat,
  output logic [NUM_LANES-1:0][DIV_W-1:0]     quo
);

  logic [NUM_LANES-1:0][DIV_W-1:0] rem;
  logic [NUM_LANES-1:0][DIV_W-1:0] rem_next;
  logic [NUM_LANES-1:0][DIV_W-1:0] quo_step;
  logic [NUM_LANES-1:0][DIV_W-1:0] quo_fix;
  logic [DIV_CNT_W-1:0]            cnt;
  logic                            busy;
  logic                            done;

  // Fold one digit per lane
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_next[i] = (rem[i] >> SCALE_SH) + (rem[i] & DIV_W'(FULL_SCALE));
      quo_step[i] = quo[i] + (rem[i] >> SCALE_SH);
      quo_fix[i]  = quo[i] + DIV_W'(rem[i] >= DIV_W'(FULL_SCALE));
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load, fold, then correct
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem <= num;
      quo <= '0;
    end else if (busy) begin
      if (cnt != '0) begin
        rem <= rem_next;
        quo <= quo_step;
      end else begin
        quo <= quo_fix;
      end
    end
  end

  assign stat.done = done;

endmodule

>>> sv/touch_contact_relative_tracker.sv
`timescale 1ns / 1ps

// A report is accepted only while the sequencer is idle, so a kept report is finished and its
// event loaded before the next one is taken; the iterative divide by 32767 is shared by x, y
// and pressure. A report that yields no event leaves the sequencer idle.
// Reset (rst, synchronous): all contacts inactive, registers at their defaults, no event.
// The contact table memory itself is not cleared; entries are used only when active.
module touch_contact_relative_tracker import tcrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tcrt_cfg_if.sink cfg,
  tcrt_rpt_if.sink rpt,
  tcrt_evt_if.source evt
);

  // Configuration registers
  logic              enable;
  logic [SIZE_W-1:0] screen_width;
  logic [SIZE_W-1:0] screen_height;
  logic [SENS_W-1:0] sensitivity;

  // Control
  state_t    state;
  state_t    state_next;
  logic      rpt_ready;
  logic      rpt_xfer;
  logic      fin_fire;
  div_ctrl_t div_ctrl;
  div_stat_t div_stat;

  // Report decode
  logic              id_ok;
  logic [CID_W-1:0]  id_idx;
  logic              keep;
  event_kind_t       kind_in;

  // Contact table
  logic [NUM_CONTACTS-1:0] active;
  entry_t                  table_mem [NUM_CONTACTS];
  entry_t                  rd_entry;
  entry_t                  wr_entry;

  // Item in flight
  logic [CID_W-1:0]  item_idx;
  event_kind_t       item_kind;
  logic [RAW_W-1:0]  item_raw_x;
  logic [RAW_W-1:0]  item_raw_y;
  logic [RAW_W-1:0]  item_raw_p;
  logic [SIZE_W-1:0] size_w;
  logic [SIZE_W-1:0] size_h;
  logic [RAW_W-1:0]  fac_x;
  logic [RAW_W-1:0]  fac_y;
  logic              neg_x;
  logic              neg_y;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  // Divider data
  logic [PROD_W+SENS_W-1:0]        gain_x;
  logic [PROD_W+SENS_W-1:0]        gain_y;
  logic [NUM_LANES-1:0][DIV_W-1:0] div_num;
  logic [NUM_LANES-1:0][DIV_W-1:0] div_quo;

  // Position update
  logic signed [NV_W-1:0] nv_base_x;
  logic signed [NV_W-1:0] nv_base_y;
  logic signed [NV_W-1:0] nv_step_x;
  logic signed [NV_W-1:0] nv_step_y;
  logic signed [NV_W-1:0] nv_x;
  logic signed [NV_W-1:0] nv_y;
  logic [POS_W-1:0]       new_x;
  logic [POS_W-1:0]       new_y;

  // Event register
  logic                evt_valid;
  logic [OUT_ID_W-1:0] evt_contact;
  event_kind_t         evt_kind;
  logic [PIX_W-1:0]    evt_px;
  logic [PIX_W-1:0]    evt_py;
  logic [PRES_W-1:0]   evt_pres;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s < SIZE_MIN) r = SIZE_MIN;
    if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [NV_W-1:0] v,
                                                  input logic [SIZE_W-1:0] size);
    logic signed [NV_W-1:0] lo;
    logic signed [NV_W-1:0] hi;
    logic signed [NV_W-1:0] r;
    lo = NV_W'(EDGE) << FRACTION_BITS;
    hi = NV_W'(size - EDGE) << FRACTION_BITS;
    r  = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return POS_W'(r);
  endfunction

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= RST_ENABLE;
      screen_width  <= RST_SCREEN_W;
      screen_height <= RST_SCREEN_H;
      sensitivity   <= RST_SENSITIVITY;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_ENABLE: enable        <= cfg.data[0];
        CFG_WIDTH:  screen_width  <= cfg.data[SIZE_W-1:0];
        CFG_HEIGHT: screen_height <= cfg.data[SIZE_W-1:0];
        CFG_SENS:   sensitivity   <= cfg.data[SENS_W-1:0];
      endcase
    end
  end

  // Decode the report at the transfer
  always_comb begin
    id_ok  = !rpt.contact_id[ID_W-1] &&
             (rpt.contact_id[ID_W-2:0] < (ID_W-1)'(NUM_CONTACTS));
    id_idx = rpt.contact_id[CID_W-1:0];
    keep   = enable && id_ok &&
             ((rpt.touch_phase == PH_TOUCH) ||
              ((rpt.touch_phase == PH_LIFT) && active[id_idx]));
    if (rpt.touch_phase == PH_LIFT) begin
      kind_in = EV_UP;
    end else if (active[id_idx]) begin
      kind_in = EV_MOVE;
    end else begin
      kind_in = EV_DOWN;
    end
  end

  assign rpt.ready = rpt_ready;
  assign rpt_xfer  = rpt.valid && rpt_ready;

  // Sequencer: read, two multiplies, divide, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    rpt_ready      = 1'b0;
    div_ctrl.start = 1'b0;
    fin_fire       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rpt_ready = 1'b1;
        if (rpt.valid && keep) state_next = ST_READ;
      end
      ST_READ: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: begin
        div_ctrl.start = 1'b1;
        state_next     = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!evt_valid || evt.ready) begin
          fin_fire   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table read; the only write lands before the next transfer, so no forwarding
  always_ff @(posedge clk) begin
    if (rpt_xfer) rd_entry <= table_mem[id_idx];
    if (fin_fire && (item_kind != EV_UP)) table_mem[item_idx] <= wr_entry;
  end

  // Active bits
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (fin_fire) begin
      if (item_kind == EV_DOWN) active[item_idx] <= 1'b1;
      if (item_kind == EV_UP)   active[item_idx] <= 1'b0;
    end
  end

  // Capture the report
  always_ff @(posedge clk) begin
    if (rpt_xfer) begin
      item_idx   <= id_idx;
      item_kind  <= kind_in;
      item_raw_x <= rpt.raw_x;
      item_raw_y <= rpt.raw_y;
      item_raw_p <= rpt.raw_pressure;
      size_w     <= eff_size(screen_width);
      size_h     <= eff_size(screen_height);
    end
  end

  // Form the factor: raw position on down, delta magnitude on move
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      if (item_kind == EV_DOWN) begin
        fac_x <= item_raw_x;
        neg_x <= 1'b0;
        fac_y <= item_raw_y;
        neg_y <= 1'b0;
      end else begin
        neg_x <= item_raw_x < rd_entry.last_x;
        fac_x <= (item_raw_x < rd_entry.last_x) ? rd_entry.last_x - item_raw_x
                                                 : item_raw_x - rd_entry.last_x;
        neg_y <= item_raw_y < rd_entry.last_y;
        fac_y <= (item_raw_y < rd_entry.last_y) ? rd_entry.last_y - item_raw_y
                                                 : item_raw_y - rd_entry.last_y;
      end
    end
  end

  // Scale by screen size
  always_ff @(posedge clk) begin
    if (state == ST_MUL1) begin
      prod_x <= fac_x * size_w;
      prod_y <= fac_y * size_h;
    end
  end

  // Apply gain or fraction shift; the divider registers the result
  always_comb begin
    gain_x = prod_x * sensitivity;
    gain_y = prod_y * sensitivity;
    if (item_kind == EV_DOWN) begin
      div_num[LANE_X] = DIV_W'(prod_x) << FRACTION_BITS;
      div_num[LANE_Y] = DIV_W'(prod_y) << FRACTION_BITS;
    end else begin
      div_num[LANE_X] = (DIV_W'(gain_x) << UP_SH) >> DN_SH;
      div_num[LANE_Y] = (DIV_W'(gain_y) << UP_SH) >> DN_SH;
    end
    div_num[LANE_P] = DIV_W'(item_raw_p) << PRES_SHIFT;
  end

  tcrt_div u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (div_num),
    .stat (div_stat),
    .quo  (div_quo)
  );

  // Anchor or advance, then clamp; up keeps the stored position
  always_comb begin
    if (item_kind == EV_DOWN) begin
      nv_base_x = '0;
      nv_base_y = '0;
    end else begin
      nv_base_x = NV_W'(rd_entry.virt_x);
      nv_base_y = NV_W'(rd_entry.virt_y);
    end
    nv_step_x = NV_W'(div_quo[LANE_X]);
    nv_step_y = NV_W'(div_quo[LANE_Y]);
    nv_x = neg_x ? nv_base_x - nv_step_x : nv_base_x + nv_step_x;
    nv_y = neg_y ? nv_base_y - nv_step_y : nv_base_y + nv_step_y;
    if (item_kind == EV_UP) begin
      new_x = rd_entry.virt_x;
      new_y = rd_entry.virt_y;
    end else begin
      new_x = clamp_pos(nv_x, size_w);
      new_y = clamp_pos(nv_y, size_h);
    end
    wr_entry.last_x = item_raw_x;
    wr_entry.last_y = item_raw_y;
    wr_entry.virt_x = new_x;
    wr_entry.virt_y = new_y;
  end

  // Event register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (fin_fire) begin
      evt_valid <= 1'b1;
    end else if (evt.ready) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      evt_contact <= OUT_ID_W'(item_idx);
      evt_kind    <= item_kind;
      evt_px      <= new_x[POS_W-1:FRACTION_BITS];
      evt_py      <= new_y[POS_W-1:FRACTION_BITS];
      evt_pres    <= PRES_W'(div_quo[LANE_P]);
    end
  end

  assign evt.valid          = evt_valid;
  assign evt.out_contact    = evt_contact;
  assign evt.event_kind     = evt_kind;
  assign evt.pixel_x        = evt_px;
  assign evt.pixel_y        = evt_py;
  assign evt.pressure_level = evt_pres;

endmodule

>>> sv/tcrt_checker.sv
`timescale 1ns / 1ps

module tcrt_checker import tcrt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                rpt_ready,
  input logic                evt_valid,
  input logic                evt_ready,
  input logic [OUT_ID_W-1:0] out_contact,
  input logic [KIND_W-1:0]   event_kind,
  input logic [PIX_W-1:0]    pixel_x,
  input logic [PIX_W-1:0]    pixel_y,
  input logic [PRES_W-1:0]   pressure_level
);

  // Hold a stalled event
  a_evt_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(out_contact) &&
      $stable(event_kind) && $stable(pixel_x) && $stable(pixel_y) &&
      $stable(pressure_level))
    else $error("event changed while stalled");

  // Reset clears the event register
  a_evt_reset: assert property (@(posedge clk)
    rst |=> !evt_valid)
    else $error("event valid after reset");

  // Positions stay inside the clamped screen, pressure within span
  a_evt_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (pixel_x >= PIX_W'(2)) && (pixel_x <= PIX_W'(8190)) &&
      (pixel_y >= PIX_W'(2)) && (pixel_y <= PIX_W'(8190)) &&
      (pressure_level <= PRES_W'(1024)))
    else $error("event field out of range");

  // A new event comes only from a busy sequencer
  a_evt_source: assert property (@(posedge clk) disable iff (rst)
    $rose(evt_valid) |-> !$past(rpt_ready))
    else $error("event raised while idle");

endmodule

bind touch_contact_relative_tracker tcrt_checker u_tcrt_checker (
  .clk            (clk),
  .rst            (rst),
  .rpt_ready      (rpt.ready),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .out_contact    (evt.out_contact),
  .event_kind     (evt.event_kind),
  .pixel_x        (evt.pixel_x),
  .pixel_y        (evt.pixel_y),
  .pressure_level (evt.pressure_level)
);

>>> sim/touch_event_checker.sv
`timescale 1ns / 1ps

module touch_event_checker import tcrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  tcrt_cfg_if  cfg,
  tcrt_rpt_if  rpt,
  tcrt_evt_if  evt,
  output int   mismatches,
  output int   pending
);

  typedef longint unsigned u64_t;

  localparam int RAW_SPAN   = 32767;
  localparam int GAIN_UNITY = 256;
  localparam int LEVEL_SPAN = 1024;

  typedef struct packed {
    logic [OUT_ID_W-1:0] contact;
    event_kind_t         kind;
    logic [PIX_W-1:0]    px;
    logic [PIX_W-1:0]    py;
    logic [PRES_W-1:0]   level;
  } touch_event_t;

  // Register shadow
  logic              en_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic [SENS_W-1:0] sens_q;

  // Contact table shadow
  logic             active_q [NUM_CONTACTS];
  logic [RAW_W-1:0] prev_x   [NUM_CONTACTS];
  logic [RAW_W-1:0] prev_y   [NUM_CONTACTS];
  logic [POS_W-1:0] pos_x    [NUM_CONTACTS];
  logic [POS_W-1:0] pos_y    [NUM_CONTACTS];

  touch_event_t expected_events[$];

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [SIZE_W-1:0] bounded_size(input logic [SIZE_W-1:0] s);
    if (s < SIZE_MIN) return SIZE_MIN;
    if (s > SIZE_MAX) return SIZE_MAX;
    return s;
  endfunction

  // Hold the position inside the edge margin of the screen
  function automatic logic [POS_W-1:0] clamp_to_screen(input longint v,
                                                       input logic [SIZE_W-1:0] s);
    longint lo;
    longint hi;
    lo = longint'(EDGE) << FRACTION_BITS;
    hi = longint'(s - EDGE) << FRACTION_BITS;
    if (v < lo) return POS_W'(lo);
    if (v > hi) return POS_W'(hi);
    return POS_W'(v);
  endfunction

  function automatic logic [POS_W-1:0] anchor_pos(input logic [RAW_W-1:0] raw,
                                                  input logic [SIZE_W-1:0] s);
    u64_t p;
    p = (u64_t'(raw) * u64_t'(s)) << FRACTION_BITS;
    return clamp_to_screen(longint'(p / u64_t'(RAW_SPAN)), s);
  endfunction

  // Scale the raw delta by screen size and gain, truncate the magnitude
  function automatic logic [POS_W-1:0] moved_pos(input logic [POS_W-1:0]  v,
                                                 input logic [RAW_W-1:0]  raw,
                                                 input logic [RAW_W-1:0]  last,
                                                 input logic [SIZE_W-1:0] s);
    logic   neg;
    u64_t   mag;
    u64_t   step;
    longint nv;
    neg  = raw < last;
    mag  = neg ? u64_t'(last - raw) : u64_t'(raw - last);
    step = ((mag * u64_t'(s) * u64_t'(sens_q)) << FRACTION_BITS)
           / (u64_t'(RAW_SPAN) * u64_t'(GAIN_UNITY));
    nv   = neg ? longint'(v) - longint'(step) : longint'(v) + longint'(step);
    return clamp_to_screen(nv, s);
  endfunction

  task automatic predict_report();
    logic [CID_W-1:0]  c;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    touch_event_t      ev;
    w = bounded_size(width_q);
    h = bounded_size(height_q);
    if (!en_q) return;
    if (rpt.contact_id < 0 || rpt.contact_id >= NUM_CONTACTS) return;
    c = rpt.contact_id[CID_W-1:0];
    if (rpt.touch_phase == PH_TOUCH && !active_q[c]) begin
      active_q[c] = 1'b1;
      prev_x[c]   = rpt.raw_x;
      prev_y[c]   = rpt.raw_y;
      pos_x[c]    = anchor_pos(rpt.raw_x, w);
      pos_y[c]    = anchor_pos(rpt.raw_y, h);
      ev.kind     = EV_DOWN;
    end else if (rpt.touch_phase == PH_TOUCH) begin
      pos_x[c]  = moved_pos(pos_x[c], rpt.raw_x, prev_x[c], w);
      pos_y[c]  = moved_pos(pos_y[c], rpt.raw_y, prev_y[c], h);
      prev_x[c] = rpt.raw_x;
      prev_y[c] = rpt.raw_y;
      ev.kind   = EV_MOVE;
    end else if (rpt.touch_phase == PH_LIFT && active_q[c]) begin
      // lift reports the stored position as is
      active_q[c] = 1'b0;
      ev.kind     = EV_UP;
    end else begin
      return;
    end
    ev.contact = OUT_ID_W'(c);
    ev.px      = pos_x[c][POS_W-1:FRACTION_BITS];
    ev.py      = pos_y[c][POS_W-1:FRACTION_BITS];
    ev.level   = PRES_W'((u64_t'(rpt.raw_pressure) * u64_t'(LEVEL_SPAN))
                         / u64_t'(RAW_SPAN));
    expected_events.push_back(ev);
  endtask

  task automatic check_event();
    touch_event_t want;
    if (expected_events.size() == 0) begin
      flag_mismatch($sformatf("unexpected event contact %0d kind %0d",
                              evt.out_contact, evt.event_kind));
      return;
    end
    want = expected_events.pop_front();
    if (evt.out_contact !== want.contact)
      flag_mismatch($sformatf("out_contact %0d, want %0d", evt.out_contact, want.contact));
    if (evt.event_kind !== want.kind)
      flag_mismatch($sformatf("event_kind %0d, want %0d", evt.event_kind, want.kind));
    if (evt.pixel_x !== want.px)
      flag_mismatch($sformatf("pixel_x %0d, want %0d", evt.pixel_x, want.px));
    if (evt.pixel_y !== want.py)
      flag_mismatch($sformatf("pixel_y %0d, want %0d", evt.pixel_y, want.py));
    if (evt.pressure_level !== want.level)
      flag_mismatch($sformatf("pressure_level %0d, want %0d",
                              evt.pressure_level, want.level));
  endtask

  // Track register writes, predict on each report transfer, compare each event transfer
  always @(posedge clk) begin
    if (rst) begin
      en_q     = RST_ENABLE;
      width_q  = RST_SCREEN_W;
      height_q = RST_SCREEN_H;
      sens_q   = RST_SENSITIVITY;
      for (int i = 0; i < NUM_CONTACTS; i++) active_q[i] = 1'b0;
      expected_events.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_idx_t'(cfg.index))
          CFG_ENABLE: en_q     = cfg.data[0];
          CFG_WIDTH:  width_q  = cfg.data[SIZE_W-1:0];
          CFG_HEIGHT: height_q = cfg.data[SIZE_W-1:0];
          CFG_SENS:   sens_q   = cfg.data[SENS_W-1:0];
          default: ;
        endcase
      end
      if (rpt.valid && rpt.ready) predict_report();
      if (evt.valid && evt.ready) check_event();
    end
    pending = expected_events.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tcrt_pkg::*;

  localparam int RAW_MAX     = 32767;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 50;

  // Phases the block ignores
  localparam logic [PHASE_W-1:0] PH_NONE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_OTHER = 2'd3;

  typedef struct packed {
    logic signed [ID_W-1:0] id;
    logic [PHASE_W-1:0]     phase;
    logic [RAW_W-1:0]       x;
    logic [RAW_W-1:0]       y;
    logic [RAW_W-1:0]       p;
  } touch_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int send_gap    = 34;
  int recv_gap    = 59;
  logic rx_hold   = 1'b0;

  // Last position offered per contact, to keep many deltas small
  logic [RAW_W-1:0] recent_x [NUM_CONTACTS];
  logic [RAW_W-1:0] recent_y [NUM_CONTACTS];

  tcrt_cfg_if cfg_ch ();
  tcrt_rpt_if rpt_ch ();
  tcrt_evt_if evt_ch ();

  touch_contact_relative_tracker dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch.sink),
    .rpt (rpt_ch.sink),
    .evt (evt_ch.source)
  );

  touch_event_checker tracker_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .rpt        (rpt_ch),
    .evt        (evt_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive the event ready; a hold-off forces it low
  always @(negedge clk) begin
    if (rx_hold) evt_ch.ready <= 1'b0;
    else evt_ch.ready <= ($urandom_range(99) >= recv_gap);
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic hold_receiver(input int cycles);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(posedge clk);
    send_gap = tx_pct;
    recv_gap = rx_pct;
    @(negedge clk);
  endtask

  // Drop valid, wait out every expected event, then let the pipeline drain
  task automatic settle(input int tail);
    rpt_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Valid stays high after the transfer; the next call or settle decides
  task automatic send_report(input logic signed [ID_W-1:0] id,
                             input logic [PHASE_W-1:0]     phase,
                             input logic [RAW_W-1:0]       x,
                             input logic [RAW_W-1:0]       y,
                             input logic [RAW_W-1:0]       p);
    while ($urandom_range(99) < send_gap) begin
      rpt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rpt_ch.valid        <= 1'b1;
    rpt_ch.contact_id   <= id;
    rpt_ch.touch_phase  <= phase;
    rpt_ch.raw_x        <= x;
    rpt_ch.raw_y        <= y;
    rpt_ch.raw_pressure <= p;
    @(posedge clk);
    while (!rpt_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] en_word,
                                input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h,
                                input logic [CFG_DATA_W-1:0] s);
    write_register(CFG_ENABLE, en_word);
    write_register(CFG_WIDTH, w);
    write_register(CFG_HEIGHT, h);
    write_register(CFG_SENS, s);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] shaped_raw(input logic [RAW_W-1:0] prev);
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return RAW_W'(RAW_MAX);
    if (pick < 55) begin
      v = int'(prev) + int'($urandom_range(600)) - 300;
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return RAW_W'(v);
    end
    return RAW_W'($urandom_range(RAW_MAX));
  endfunction

  // Mostly touch and lift on a few contacts; some bad ids and ignored phases
  function automatic touch_report_t random_report();
    touch_report_t    r;
    int               pick;
    logic [CID_W-1:0] slot;
    pick = $urandom_range(99);
    if (pick < 50) r.id = ID_W'($urandom_range(3));
    else if (pick < 93) r.id = ID_W'($urandom_range(NUM_CONTACTS - 1));
    else r.id = ID_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 62) r.phase = PH_TOUCH;
    else if (pick < 86) r.phase = PH_LIFT;
    else if (pick < 93) r.phase = PH_NONE;
    else r.phase = PH_OTHER;
    slot = r.id[CID_W-1:0];
    r.x = shaped_raw(recent_x[slot]);
    r.y = shaped_raw(recent_y[slot]);
    pick = $urandom_range(99);
    if (pick < 10) r.p = '0;
    else if (pick < 20) r.p = RAW_W'(RAW_MAX);
    else r.p = RAW_W'($urandom_range(RAW_MAX));
    if (r.id >= 0 && r.id < NUM_CONTACTS) begin
      recent_x[slot] = r.x;
      recent_y[slot] = r.y;
    end
    return r;
  endfunction

  task automatic program_segment(input int seg);
    logic [CFG_DATA_W-1:0] en_word;
    en_word = {(CFG_DATA_W-1)'($urandom), 1'b1};
    case (seg)
      0: apply_settings(en_word, 16'd1920, 16'd1080, 16'd256);
      1: apply_settings(en_word, 16'd4, 16'd8192, 16'hFFFF);
      2: apply_settings(en_word, 16'd8192, 16'd4, 16'd0);
      4: apply_settings(en_word, 16'd2, 16'hFFFF, 16'd1);
      6: apply_settings(en_word, 16'd0, 16'd9000, 16'd512);
      7: apply_settings(en_word, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                        CFG_DATA_W'($urandom));
      8: apply_settings(en_word, 16'd8192, 16'd8192, 16'hFFFF);
      default: apply_settings(en_word, CFG_DATA_W'($urandom_range(8192, 4)),
                              CFG_DATA_W'($urandom_range(8192, 4)),
                              CFG_DATA_W'($urandom_range(65535)));
    endcase
  endtask

  initial begin : stimulus
    touch_report_t r;
    for (int i = 0; i < NUM_CONTACTS; i++) begin
      recent_x[i] = RAW_W'(16384);
      recent_y[i] = RAW_W'(16384);
    end
    rpt_ch.valid        = 1'b0;
    rpt_ch.contact_id   = '0;
    rpt_ch.touch_phase  = PH_NONE;
    rpt_ch.raw_x        = '0;
    rpt_ch.raw_y        = '0;
    rpt_ch.raw_pressure = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_ENABLE;
    cfg_ch.data         = '0;
    evt_ch.ready        = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Disabled block: reports are dropped
    apply_settings(16'hFFFE, 16'd1920, 16'd1080, 16'd256);
    send_report(8'sd0, PH_TOUCH, 15'd100, 15'd200, 15'd300);
    send_report(8'sd0, PH_LIFT, 15'd100, 15'd200, 15'd300);
    settle(20);
    write_register(CFG_ENABLE, 16'h0001);
    cfg_ch.valid <= 1'b0;

    // Anchor at the low edge, full-scale moves both ways, then lift
    send_report(8'sd0, PH_TOUCH, 15'd0, 15'd0, 15'd0);
    send_report(8'sd0, PH_TOUCH, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_report(8'sd0, PH_TOUCH, 15'd0, 15'd0, 15'd1);
    send_report(8'sd0, PH_LIFT, 15'd5000, 15'd6000, 15'd16384);
    // lift on an inactive contact
    send_report(8'sd0, PH_LIFT, 15'd0, 15'd0, 15'd32766);
    // highest id, anchored at the high edge, zero delta move
    send_report(8'sd15, PH_TOUCH, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_report(8'sd15, PH_TOUCH, 15'h7FFF, 15'h7FFF, 15'd0);
    // ignored phases
    send_report(8'sd15, PH_NONE, 15'd10, 15'd10, 15'd10);
    send_report(8'sd15, PH_OTHER, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    // ids out of range
    send_report(-8'sd1, PH_TOUCH, 15'd1000, 15'd1000, 15'd1000);
    send_report(-8'sd128, PH_TOUCH, 15'h5555, 15'h2AAA, 15'h5555);
    send_report(8'sd16, PH_TOUCH, 15'h2AAA, 15'h5555, 15'h2AAA);
    send_report(8'sd127, PH_LIFT, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    // small moves near the middle
    send_report(8'sd5, PH_TOUCH, 15'd16384, 15'd8000, 15'd12000);
    send_report(8'sd5, PH_TOUCH, 15'd16390, 15'd7990, 15'd12001);
    send_report(8'sd5, PH_TOUCH, 15'd16300, 15'd8100, 15'd20000);
    send_report(8'sd5, PH_LIFT, 15'd0, 15'd0, 15'h7FFF);
    send_report(8'sd15, PH_LIFT, 15'd0, 15'd0, 15'd2);

    // Random segments, each under its own register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle(20);
      if (seg == 0) set_idling(34, 59);
      else if (seg == 3) set_idling(59, 34);
      else if (seg == 6) set_idling(0, 0);
      program_segment(seg);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        if (seg == 6 && k == 5) begin
          fork
            hold_receiver(400);
          join_none
        end
        if (seg == 3 && k == 25) settle(20);
        r = random_report();
        send_report(r.id, r.phase, r.x, r.y, r.p);
      end
    end

    settle(30);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/tcrt_pkg.sv
sv/tcrt_rpt_if.sv
sv/tcrt_evt_if.sv
sv/tcrt_cfg_if.sv
sv/tcrt_div.sv
sv/touch_contact_relative_tracker.sv
sv/tcrt_checker.sv
sim/touch_event_checker.sv
sim/testbench.sv
